// ----- rtl/ncod_pkg.sv -----
// Shared constants and the sine table generator for the NCO derotator.
`default_nettype none

package ncod_pkg;

    // Port widths fixed by the sample and phase formats
    localparam int DATA_W  = 16;
    localparam int PHASE_W = 32;
    localparam int LEN_W   = 16;

    // Defaults for the top-level parameters
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    // pi/2 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Oscillator state memory layout
    localparam int             STATE_DEPTH     = 2;
    localparam logic [0:0]     STATE_ADDR_ACC  = 1'b0;
    localparam logic [0:0]     STATE_ADDR_STEP = 1'b1;

    // Quarter-wave sine entry p: sin(pi/2 * p / 2^qb) in Q1.(sb-1), Taylor sum in Q2.30.
    // Evaluated at elaboration only.
    function automatic longint quarter_sine(input int p, input int qb, input int sb);
        longint unsigned pu;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        longint          top;
        int              shift;
        int              n;
        pu    = p;
        x     = (HALF_PI_Q30 * pu + (64'd1 << (qb - 1))) >> qb;
        x2    = (x * x) >> 30;
        term  = x;
        sum   = longint'(x);
        shift = 30 - (sb - 1);
        top   = (64'sd1 <<< (sb - 1)) - 64'sd1;
        for (n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                5: term = term / 64'd110;
                6: term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if (n[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum + (64'sd1 <<< (shift - 1))) >>> shift;
        if (v > top) begin
            v = top;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ncod_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ncod_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/nco_phase_freq_derotator.sv -----
// Top level of the NCO complex derotator.
`default_nettype none

// Rotates each complex Q1.15 sample by exp(j*2*pi*phase) and advances the phase
// by a per-sample increment; a transfer flagged new_estimate first reloads the
// increment with -freq_offset and the phase with phase_offset - freq_offset *
// preamble_length (all phases in 32-bit turns, wrapping). Results are rounded
// half up and saturated to 16 bits. Each sample passes through these steps
// (accept, read-modify-write of phase and increment in the two-entry state
// memory, two reads of the single-read-port quarter-wave sine memory, two
// multiply steps, round/saturate); a new sample is taken only once the last
// one is finished, and a result waiting in the output register does not
// hold up the next sample until that one is finished. After reset the sine
// memory is loaded and the state memory zeroed, during which s_ready stays
// low; cfg_ready is always high.
module nco_phase_freq_derotator #(
    parameter int TABLE_ADDR_BITS = ncod_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = ncod_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [ncod_pkg::LEN_W-1:0]    cfg_preamble_length,
    // sample input
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [ncod_pkg::DATA_W-1:0]   s_sample_i,
    input  wire logic signed [ncod_pkg::DATA_W-1:0]   s_sample_q,
    input  wire logic                                 s_new_estimate,
    input  wire logic signed [ncod_pkg::PHASE_W-1:0]  s_freq_offset,
    input  wire logic signed [ncod_pkg::PHASE_W-1:0]  s_phase_offset,
    // rotated output
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [ncod_pkg::DATA_W-1:0]        m_out_i,
    output logic signed [ncod_pkg::DATA_W-1:0]        m_out_q
);

    localparam int DATA_W       = ncod_pkg::DATA_W;
    localparam int PHASE_W      = ncod_pkg::PHASE_W;
    localparam int LEN_W        = ncod_pkg::LEN_W;
    localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
    localparam int QLEN         = 2 ** QUARTER_BITS;
    localparam int ROM_DEPTH    = QLEN + 1;
    localparam int ROM_AW       = QUARTER_BITS + 1;     // $clog2(QLEN + 1)
    localparam int ROM_W        = SAMPLE_BITS - 1;      // table entries are non-negative
    localparam int PROD_W       = DATA_W + SAMPLE_BITS;
    localparam int SUM_W        = PROD_W + 1;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(2 ** (SAMPLE_BITS - 2));
    localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'(2 ** (DATA_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO     = ~SAT_HI;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,  // wait for a transfer, read phase
        S_LOAD_ACC  = 8'b0000_0010,  // phase arrives, read increment
        S_LOAD_STEP = 8'b0000_0100,  // increment arrives, write phase back, read cos entry
        S_READ_T1   = 8'b0000_1000,  // write increment back, read sin entry
        S_TAKE_T1   = 8'b0001_0000,  // fold quadrant into cos/sin
        S_MUL_A     = 8'b0010_0000,  // i*c, q*s
        S_MUL_B     = 8'b0100_0000,  // i*s, q*c
        S_FINISH    = 8'b1000_0000   // round, saturate, hand to output register
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic                       fill_busy_reg;
    logic [ROM_AW-1:0]          fill_cnt_reg;
    logic [LEN_W-1:0]           preamble_length_reg;
    logic                       m_valid_reg;
    logic signed [DATA_W-1:0]   out_i_reg, out_q_reg;

    // item payload
    logic signed [DATA_W-1:0]   si_reg, sq_reg;
    logic                       new_est_reg;
    logic [PHASE_W-1:0]         freq_reg;
    logic [PHASE_W-1:0]         phase_off_reg;
    logic [PHASE_W-1:0]         prod_reg;       // freq_offset * preamble_length, mod 2^32
    logic [PHASE_W-1:0]         acc_reg;
    logic [PHASE_W-1:0]         step_reg;
    logic [ROM_W-1:0]           t0_reg;
    logic signed [SAMPLE_BITS-1:0] c_reg, s_reg;
    logic signed [PROD_W-1:0]   prod_a_reg, prod_b_reg, prod_c_reg, prod_d_reg;

    // ------------------------------------------------------------------
    // Constant sine table, copied into the RAM after reset
    // ------------------------------------------------------------------
    logic [ROM_W-1:0] rom_const [ROM_DEPTH];

    for (genvar g = 0; g <= QLEN; g++) begin : g_rom
        localparam logic [ROM_W-1:0] ENTRY =
            ROM_W'(ncod_pkg::quarter_sine(g, QUARTER_BITS, SAMPLE_BITS));
        assign rom_const[g] = ENTRY;
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic               rom_we;
    logic [ROM_AW-1:0]  rom_raddr;
    logic [ROM_W-1:0]   rom_rdata;

    logic               st_we;
    logic [0:0]         st_waddr;
    logic [PHASE_W-1:0] st_wdata;
    logic [0:0]         st_raddr;
    logic [PHASE_W-1:0] st_rdata;

    ncod_ram #(
        .WIDTH (ROM_W),
        .DEPTH (ROM_DEPTH)
    ) u_sine_ram (
        .aclk  (aclk),
        .we    (rom_we),
        .waddr (fill_cnt_reg),
        .wdata (rom_const[fill_cnt_reg]),
        .raddr (rom_raddr),
        .rdata (rom_rdata)
    );

    ncod_ram #(
        .WIDTH (PHASE_W),
        .DEPTH (ncod_pkg::STATE_DEPTH)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                        s_fire;
    logic                        out_load;
    logic [PHASE_W+LEN_W-1:0]    mul_full;
    logic [PHASE_W-1:0]          step_cur;
    logic [QUARTER_BITS-1:0]     quad_pos;
    logic [1:0]                  quad;
    logic signed [SAMPLE_BITS-1:0] t0_s, t1_s;
    logic signed [SAMPLE_BITS-1:0] c_next, s_next;
    logic signed [SUM_W-1:0]     sum_i, sum_q;

    assign s_fire = s_valid && s_ready;

    // start-phase correction, from the freq_offset port and the stored preamble length, captured on accept
    assign mul_full = (PHASE_W+LEN_W)'($unsigned(s_freq_offset))
                    * (PHASE_W+LEN_W)'(preamble_length_reg);

    // increment: fresh estimate wins over the stored one
    assign step_cur = new_est_reg ? (PHASE_W'(0) - freq_reg) : st_rdata;

    assign quad     = acc_reg[PHASE_W-1 -: 2];
    assign quad_pos = acc_reg[PHASE_W-3 -: QUARTER_BITS];

    assign t0_s = $signed({1'b0, t0_reg});
    assign t1_s = $signed({1'b0, rom_rdata});

    always_comb begin
        case (quad)
            QUAD_0: begin
                c_next = t0_s;
                s_next = t1_s;
            end
            QUAD_1: begin
                c_next = -t1_s;
                s_next = t0_s;
            end
            QUAD_2: begin
                c_next = -t0_s;
                s_next = -t1_s;
            end
            default: begin
                c_next = t1_s;
                s_next = -t0_s;
            end
        endcase
    end

    assign sum_i = SUM_W'(prod_a_reg) - SUM_W'(prod_b_reg);
    assign sum_q = SUM_W'(prod_c_reg) + SUM_W'(prod_d_reg);

    // round half up, then clamp to the 16-bit range
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] shifted;
        shifted = (v + ROUND_BIAS) >>> (SAMPLE_BITS - 1);
        if (shifted > SAT_HI) begin
            return SAT_HI[DATA_W-1:0];
        end else if (shifted < SAT_LO) begin
            return SAT_LO[DATA_W-1:0];
        end else begin
            return shifted[DATA_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Memory port control
    // ------------------------------------------------------------------
    always_comb begin
        rom_we    = fill_busy_reg;
        rom_raddr = (state_reg == S_LOAD_STEP)
                  ? (ROM_AW'(QLEN) - {1'b0, quad_pos})   // cos side of the quarter
                  : {1'b0, quad_pos};

        // state memory: zeroed during the load, otherwise written back in the
        // consecutive steps S_LOAD_STEP and S_READ_T1; the next read only comes after
        // S_FINISH, so no forwarding path is needed
        st_raddr = (state_reg == S_LOAD_ACC) ? ncod_pkg::STATE_ADDR_STEP
                                             : ncod_pkg::STATE_ADDR_ACC;
        if (fill_busy_reg) begin
            st_we    = (fill_cnt_reg[ROM_AW-1:1] == '0);
            st_waddr = fill_cnt_reg[0];
            st_wdata = '0;
        end else if (state_reg == S_LOAD_STEP) begin
            st_we    = 1'b1;
            st_waddr = ncod_pkg::STATE_ADDR_ACC;
            st_wdata = acc_reg + step_cur;
        end else begin
            st_we    = (state_reg == S_READ_T1);
            st_waddr = ncod_pkg::STATE_ADDR_STEP;
            st_wdata = step_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_load = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_fire) state_next = S_LOAD_ACC;
            S_LOAD_ACC:  state_next = S_LOAD_STEP;
            S_LOAD_STEP: state_next = S_READ_T1;
            S_READ_T1:   state_next = S_TAKE_T1;
            S_TAKE_T1:   state_next = S_MUL_A;
            S_MUL_A:     state_next = S_MUL_B;
            S_MUL_B:     state_next = S_FINISH;
            S_FINISH:    if (out_load) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            fill_busy_reg       <= 1'b1;
            fill_cnt_reg        <= '0;
            preamble_length_reg <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fill_busy_reg) begin
                fill_cnt_reg <= fill_cnt_reg + ROM_AW'(1);
                if (fill_cnt_reg == ROM_AW'(QLEN)) begin
                    fill_busy_reg <= 1'b0;
                end
            end
            if (cfg_valid && cfg_ready) begin
                preamble_length_reg <= cfg_preamble_length;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            si_reg        <= s_sample_i;
            sq_reg        <= s_sample_q;
            new_est_reg   <= s_new_estimate;
            freq_reg      <= s_freq_offset;
            phase_off_reg <= s_phase_offset;
            prod_reg      <= mul_full[PHASE_W-1:0];
        end
        if (state_reg == S_LOAD_ACC) begin
            acc_reg <= new_est_reg ? (phase_off_reg - prod_reg) : st_rdata;
        end
        if (state_reg == S_LOAD_STEP) begin
            step_reg <= step_cur;
        end
        if (state_reg == S_READ_T1) begin
            t0_reg <= rom_rdata;
        end
        if (state_reg == S_TAKE_T1) begin
            c_reg <= c_next;
            s_reg <= s_next;
        end
        if (state_reg == S_MUL_A) begin
            prod_a_reg <= PROD_W'(si_reg) * PROD_W'(c_reg);
            prod_b_reg <= PROD_W'(sq_reg) * PROD_W'(s_reg);
        end
        if (state_reg == S_MUL_B) begin
            prod_c_reg <= PROD_W'(si_reg) * PROD_W'(s_reg);
            prod_d_reg <= PROD_W'(sq_reg) * PROD_W'(c_reg);
        end
        if (out_load) begin
            out_i_reg <= round_sat(sum_i);
            out_q_reg <= round_sat(sum_q);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE) && !fill_busy_reg;
    assign m_valid   = m_valid_reg;
    assign m_out_i   = out_i_reg;
    assign m_out_q   = out_q_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // table load runs once per reset
    a_fill_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !fill_busy_reg |=> !fill_busy_reg)
        else $error("sine table load restarted");

    // a new result only ever comes out of the finishing step
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == S_FINISH)
        else $error("result raised outside finishing step");

    // after reset, state memory writes only happen in the write-back steps
    a_state_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_we && !fill_busy_reg) |-> (state_reg == S_LOAD_STEP || state_reg == S_READ_T1))
        else $error("unexpected state memory write");

    // a fresh estimate sets the start phase before the table lookup
    a_est_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD_STEP && new_est_reg) |-> acc_reg == (phase_off_reg - prod_reg))
        else $error("start phase not loaded from estimate");
`endif

endmodule

`default_nettype wire
